// File: hw/rtl/clbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the class load backpressure controller.
// Depends on nothing; imported by every module of the block.
package clbc_pkg;

  localparam int CLASS_ID_W = 4;
  localparam int AMOUNT_W   = 16;
  localparam int ACTION_W   = 2;
  localparam int PCT_W      = 7;
  localparam int LEVEL_W    = 4;
  localparam int TICK_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [ACTION_W-1:0] ACT_IN   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_OUT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LOAD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LOAD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CAPACITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 3'd5;

  localparam logic [PCT_W-1:0]   PCT_FULL          = 7'd100;
  localparam logic [PCT_W-1:0]   RST_HIGH_LOAD     = 7'd80;
  localparam logic [PCT_W-1:0]   RST_LOW_LOAD      = 7'd30;
  localparam logic [PCT_W-1:0]   RST_STEP          = 7'd10;
  localparam logic [PCT_W-1:0]   RST_MIN_CAPACITY  = 7'd50;
  localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL     = 4'd7;
  localparam logic [TICK_W-1:0]  RST_INTERVAL      = 20'd1000;

  typedef struct packed {
    logic                  cnt_in;
    logic                  cnt_out;
    logic                  tick;
    logic                  prod;
    logic                  upd;
    logic [CLASS_ID_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic tick_fire;
    logic cls_in_range;
  } stat_t;

endpackage

// File: hw/rtl/class_load_backpressure_controller.sv
`timescale 1ns / 1ps
// Count beats are taken every cycle while the input is not stalled and update the class
// counters directly. A tick beat that closes the interval stalls the input and walks
// the classes, each through a product stage and then an update stage; each result is
// registered in the update stage, which waits while the result side stalls, and the
// input stays stalled until the last class has been updated.
// Synchronous active-low reset restores register defaults and clears all class state.
module class_load_backpressure_controller #(
  parameter int NUM_CLASSES = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [clbc_pkg::ACTION_W-1:0]     in_action,
  input  logic [clbc_pkg::CLASS_ID_W-1:0]   in_class_id,
  input  logic [clbc_pkg::AMOUNT_W-1:0]     in_amount,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [clbc_pkg::CLASS_ID_W-1:0]   out_class_index,
  output logic [clbc_pkg::PCT_W-1:0]        out_capacity,
  output logic [clbc_pkg::LEVEL_W-1:0]      out_level,
  output logic                              out_overloaded,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import clbc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  clbc_ctrl #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  clbc_datapath #(
    .NUM_CLASSES(NUM_CLASSES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_class_id     (in_class_id),
    .in_amount       (in_amount),
    .out_class_index (out_class_index),
    .out_capacity    (out_capacity),
    .out_level       (out_level),
    .out_overloaded  (out_overloaded),
    .out_last        (out_last)
  );

endmodule

// File: hw/rtl/clbc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the class load backpressure controller: handshakes and class walk.
// Depends on clbc_pkg; drives commands into clbc_datapath.
module clbc_ctrl #(
  parameter int NUM_CLASSES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [clbc_pkg::ACTION_W-1:0]   in_action,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  clbc_pkg::stat_t                 stat,
  output clbc_pkg::cmd_t                  cmd
);
  import clbc_pkg::*;

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PROD = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CLS_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_beat;
  logic             out_free;
  logic             idx_last;

  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_last = (idx_r == CLS_W'(NUM_CLASSES - 1));
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.idx     = CLASS_ID_W'(idx_r);
    cmd.cnt_in  = in_beat && (in_action == ACT_IN);
    cmd.cnt_out = in_beat && (in_action == ACT_OUT);
    cmd.tick    = in_beat && (in_action == ACT_TICK);
    cmd.prod    = (state_r == S_PROD);
    cmd.upd     = (state_r == S_UPD) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.tick && stat.tick_fire) begin
          state_nxt = S_PROD;
          idx_nxt   = '0;
        end
      end
      S_PROD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_PROD;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/clbc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the class load backpressure controller: counters, thresholds, levels.
// Depends on clbc_pkg; commanded by clbc_ctrl.
module clbc_datapath #(
  parameter int NUM_CLASSES = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  clbc_pkg::cmd_t                    cmd,
  output clbc_pkg::stat_t                   stat,
  input  logic                              cfg_we,
  input  logic [clbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [clbc_pkg::CLASS_ID_W-1:0]   in_class_id,
  input  logic [clbc_pkg::AMOUNT_W-1:0]     in_amount,
  output logic [clbc_pkg::CLASS_ID_W-1:0]   out_class_index,
  output logic [clbc_pkg::PCT_W-1:0]        out_capacity,
  output logic [clbc_pkg::LEVEL_W-1:0]      out_level,
  output logic                              out_overloaded,
  output logic                              out_last
);
  import clbc_pkg::*;

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SUM_W  = ((COUNT_WIDTH > AMOUNT_W) ? COUNT_WIDTH : AMOUNT_W) + 1;
  localparam int PROD_W = COUNT_WIDTH + PCT_W;
  localparam int DROP_W = LEVEL_W + PCT_W;

  function automatic logic [PCT_W-1:0] cap_for(input logic [LEVEL_W-1:0] lvl,
                                               input logic [PCT_W-1:0]   step,
                                               input logic [PCT_W-1:0]   min_cap);
    logic [DROP_W-1:0] drop;
    logic [PCT_W-1:0]  cap;
    drop = DROP_W'(lvl) * DROP_W'(step);
    cap  = (drop >= DROP_W'(PCT_FULL)) ? '0 : PCT_W'(DROP_W'(PCT_FULL) - drop);
    if (cap < min_cap) begin
      cap = min_cap;
    end
    return cap;
  endfunction

  logic [PCT_W-1:0]       high_pct_r, low_pct_r, step_pct_r, min_cap_r;
  logic [LEVEL_W-1:0]     max_level_r;
  logic [TICK_W-1:0]      interval_r;
  logic [TICK_W-1:0]      elapsed_r;

  logic [COUNT_WIDTH-1:0] in_cnt_r  [NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] out_cnt_r [NUM_CLASSES];
  logic [LEVEL_W-1:0]     level_r   [NUM_CLASSES];
  logic                   flag_r    [NUM_CLASSES];
  logic [PCT_W-1:0]       cap_r     [NUM_CLASSES];

  logic [PROD_W-1:0]      p_out_r, p_hi_r, p_lo_r;
  logic                   in_zero_r;
  logic [LEVEL_W-1:0]     lvl_r;
  logic [PCT_W-1:0]       cap_up_r, cap_dn_r;
  logic                   raise_ok_r, lower_ok_r;

  logic [TICK_W-1:0]      tick_inc;
  logic                   is_count;
  logic [CLS_W-1:0]       sel;
  logic [COUNT_WIDTH-1:0] ev_in, ev_out, cnt_cur, cnt_sat;
  logic [SUM_W-1:0]       cnt_sum;
  logic [LEVEL_W-1:0]     lvl_up, lvl_dn, lvl_new;
  logic                   load_high, load_low, flag_new;
  logic [PCT_W-1:0]       cap_new;

  assign tick_inc          = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign stat.tick_fire    = (tick_inc >= interval_r);
  assign stat.cls_in_range = ({1'b0, in_class_id} < (CLASS_ID_W + 1)'(NUM_CLASSES));

  assign is_count = cmd.cnt_in || cmd.cnt_out;
  assign sel      = is_count ? in_class_id[CLS_W-1:0] : cmd.idx[CLS_W-1:0];
  assign ev_in    = in_cnt_r[sel];
  assign ev_out   = out_cnt_r[sel];
  assign cnt_cur  = cmd.cnt_in ? ev_in : ev_out;
  assign cnt_sum  = SUM_W'(cnt_cur) + SUM_W'(in_amount);
  assign cnt_sat  = (|cnt_sum[SUM_W-1:COUNT_WIDTH]) ? '1 : cnt_sum[COUNT_WIDTH-1:0];

  assign lvl_up = level_r[sel] + 1'b1;
  assign lvl_dn = level_r[sel] - 1'b1;

  always_comb begin
    load_high = !in_zero_r && (p_out_r > p_hi_r);
    load_low  = in_zero_r ? (low_pct_r != '0) : (p_out_r < p_lo_r);
    flag_new  = flag_r[sel];
    lvl_new   = lvl_r;
    cap_new   = cap_r[sel];
    if (load_high) begin
      flag_new = 1'b1;
      if (raise_ok_r) begin
        lvl_new = lvl_r + 1'b1;
        cap_new = cap_up_r;
      end
    end else if (load_low) begin
      flag_new = 1'b0;
      if (lower_ok_r) begin
        lvl_new = lvl_r - 1'b1;
        cap_new = cap_dn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_pct_r  <= RST_HIGH_LOAD;
      low_pct_r   <= RST_LOW_LOAD;
      step_pct_r  <= RST_STEP;
      min_cap_r   <= RST_MIN_CAPACITY;
      max_level_r <= RST_MAX_LEVEL;
      interval_r  <= RST_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH_LOAD:    high_pct_r  <= cfg_data[PCT_W-1:0];
        REG_LOW_LOAD:     low_pct_r   <= cfg_data[PCT_W-1:0];
        REG_STEP:         step_pct_r  <= cfg_data[PCT_W-1:0];
        REG_MIN_CAPACITY: min_cap_r   <= cfg_data[PCT_W-1:0];
        REG_MAX_LEVEL:    max_level_r <= cfg_data[LEVEL_W-1:0];
        REG_INTERVAL:     interval_r  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (cmd.tick) begin
      elapsed_r <= stat.tick_fire ? '0 : tick_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        in_cnt_r[i]  <= '0;
        out_cnt_r[i] <= '0;
        level_r[i]   <= '0;
        flag_r[i]    <= 1'b0;
        cap_r[i]     <= PCT_FULL;
      end
    end else begin
      if (cmd.cnt_in && stat.cls_in_range) begin
        in_cnt_r[sel] <= cnt_sat;
      end
      if (cmd.cnt_out && stat.cls_in_range) begin
        out_cnt_r[sel] <= cnt_sat;
      end
      if (cmd.upd) begin
        in_cnt_r[sel]  <= '0;
        out_cnt_r[sel] <= '0;
        level_r[sel]   <= lvl_new;
        flag_r[sel]    <= flag_new;
        cap_r[sel]     <= cap_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      p_out_r    <= PROD_W'(ev_out) * PROD_W'(PCT_FULL);
      p_hi_r     <= PROD_W'(ev_in) * PROD_W'(high_pct_r);
      p_lo_r     <= PROD_W'(ev_in) * PROD_W'(low_pct_r);
      in_zero_r  <= (ev_in == '0);
      lvl_r      <= level_r[sel];
      cap_up_r   <= cap_for(lvl_up, step_pct_r, min_cap_r);
      cap_dn_r   <= cap_for(lvl_dn, step_pct_r, min_cap_r);
      raise_ok_r <= (level_r[sel] < max_level_r);
      lower_ok_r <= (level_r[sel] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_class_index <= CLASS_ID_W'(sel);
      out_capacity    <= cap_new;
      out_level       <= lvl_new;
      out_overloaded  <= flag_new;
      out_last        <= (sel == CLS_W'(NUM_CLASSES - 1));
    end
  end

endmodule

// File: hw/rtl/clbc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the class load backpressure controller.
// Depends on clbc_pkg; bound to the top level below.
module clbc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [clbc_pkg::CLASS_ID_W-1:0]   out_class_index,
  input logic [clbc_pkg::PCT_W-1:0]        out_capacity,
  input logic [clbc_pkg::LEVEL_W-1:0]      out_level,
  input logic                              out_overloaded,
  input logic                              out_last
);
  import clbc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_class_index) && $stable(out_capacity)
      && $stable(out_level) && $stable(out_overloaded) && $stable(out_last))
    else $error("stalled result beat changed");

  a_busy_mid_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken before the evaluation walk finished");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("control state not cleared by reset");

endmodule

bind class_load_backpressure_controller clbc_checker u_clbc_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for class_load_backpressure_controller.
// Imports clbc_pkg and predicts every class result from its own copy of the
// counters, levels and registers; needs nothing but the RTL.
module tb;
  import clbc_pkg::*;

  localparam int NCLS = 4;
  localparam int COUNT_W = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 4 * NCLS + 16;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TICK_W-1:0] TICK_SAT = {TICK_W{1'b1}};

  typedef struct packed {
    logic [ACTION_W-1:0]   act;
    logic [CLASS_ID_W-1:0] cls;
    logic [AMOUNT_W-1:0]   amt;
    logic                  typed;
    logic [PCT_W-1:0]      cap;
    logic [LEVEL_W-1:0]    lvl;
    logic                  ovl;
  } load_beat_t;

  typedef struct packed {
    logic [CLASS_ID_W-1:0] class_index;
    logic [PCT_W-1:0]      capacity;
    logic [LEVEL_W-1:0]    level;
    logic                  overloaded;
    logic                  last;
  } grant_t;

  typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_t;

  // Typed tail of a directed row: no typed result, or every class idle at full capacity.
  localparam logic [12:0] UNTYPED = 13'd0;
  localparam logic [12:0] RESTED = {1'b1, 7'd100, 4'd0, 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] in_action = '0;
  logic [CLASS_ID_W-1:0] in_class_id = '0;
  logic [AMOUNT_W-1:0] in_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CLASS_ID_W-1:0] out_class_index;
  logic [PCT_W-1:0] out_capacity;
  logic [LEVEL_W-1:0] out_level;
  logic out_overloaded;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  class_load_backpressure_controller #(
    .NUM_CLASSES(NCLS),
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_class_id(in_class_id),
    .in_amount(in_amount),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_class_index(out_class_index),
    .out_capacity(out_capacity),
    .out_level(out_level),
    .out_overloaded(out_overloaded),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [PCT_W-1:0] thr_high, thr_low, step_now, floor_now;
  logic [LEVEL_W-1:0] level_cap;
  logic [TICK_W-1:0] interval_now;
  logic [COUNT_W-1:0] in_tally [NCLS];
  logic [COUNT_W-1:0] out_tally [NCLS];
  logic [LEVEL_W-1:0] class_level [NCLS];
  logic class_overload [NCLS];
  logic [PCT_W-1:0] class_capacity [NCLS];
  logic [TICK_W-1:0] ticks_seen;

  grant_t pending_grants[$];
  grant_t head;
  load_beat_t cur_beat = '0;
  int mismatches = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  flow_t flow = FLOW_FREE;
  int flow_left = 0;

  load_beat_t probe_rows [19] = '{
    {ACT_TICK, 4'd0,  16'd0,     RESTED},
    {ACT_IN,   4'd0,  16'd100,   UNTYPED},
    {ACT_OUT,  4'd0,  16'd100,   UNTYPED},
    {ACT_IN,   4'd1,  16'd65535, UNTYPED},
    {ACT_OUT,  4'd1,  16'd0,     UNTYPED},
    {ACT_IN,   4'd2,  16'd100,   UNTYPED},
    {ACT_OUT,  4'd2,  16'd30,    UNTYPED},
    {ACT_IN,   4'd3,  16'd100,   UNTYPED},
    {ACT_OUT,  4'd3,  16'd80,    UNTYPED},
    {ACT_IN,   4'd15, 16'd65535, UNTYPED},
    {ACT_NONE, 4'd1,  16'd65535, UNTYPED},
    {ACT_OUT,  4'd4,  16'd500,   UNTYPED},
    {ACT_TICK, 4'd15, 16'd65535, UNTYPED},
    {ACT_IN,   4'd2,  16'd1,     UNTYPED},
    {ACT_OUT,  4'd2,  16'd65535, UNTYPED},
    {ACT_OUT,  4'd3,  16'd65535, UNTYPED},
    {ACT_IN,   4'd0,  16'd0,     UNTYPED},
    {ACT_TICK, 4'd0,  16'd0,     UNTYPED},
    {ACT_TICK, 4'd0,  16'd0,     RESTED}
  };

  function automatic void reset_model();
    thr_high = RST_HIGH_LOAD;
    thr_low = RST_LOW_LOAD;
    step_now = RST_STEP;
    floor_now = RST_MIN_CAPACITY;
    level_cap = RST_MAX_LEVEL;
    interval_now = RST_INTERVAL;
    ticks_seen = '0;
    for (int c = 0; c < NCLS; c++) begin
      in_tally[c] = '0;
      out_tally[c] = '0;
      class_level[c] = '0;
      class_overload[c] = 1'b0;
      class_capacity[c] = PCT_FULL;
    end
  endfunction

  function automatic logic [PCT_W-1:0] granted_at(input logic [LEVEL_W-1:0] lvl);
    int drop;
    int cap;
    drop = int'(lvl) * int'(step_now);
    cap = (drop >= int'(PCT_FULL)) ? 0 : int'(PCT_FULL) - drop;
    if (cap < int'(floor_now))
      cap = int'(floor_now);
    return cap[PCT_W-1:0];
  endfunction

  function automatic void predict_beat(input logic [ACTION_W-1:0] act,
                                       input logic [CLASS_ID_W-1:0] cls,
                                       input logic [AMOUNT_W-1:0] amt);
    longint unsigned sum;
    longint unsigned ins;
    longint unsigned outs;
    bit heavy;
    bit light;
    grant_t g;
    if ((act == ACT_IN || act == ACT_OUT) && cls < NCLS) begin
      if (act == ACT_IN) begin
        sum = in_tally[cls] + amt;
        in_tally[cls] = (sum > CNT_MAX) ? CNT_MAX : sum[COUNT_W-1:0];
      end else begin
        sum = out_tally[cls] + amt;
        out_tally[cls] = (sum > CNT_MAX) ? CNT_MAX : sum[COUNT_W-1:0];
      end
    end else if (act == ACT_TICK) begin
      if (ticks_seen != TICK_SAT)
        ticks_seen = ticks_seen + 1'b1;
      if (ticks_seen >= interval_now) begin
        ticks_seen = '0;
        for (int c = 0; c < NCLS; c++) begin
          ins = in_tally[c];
          outs = out_tally[c];
          if (ins == 0) begin
            heavy = 1'b0;
            light = (thr_low != 0);
          end else begin
            heavy = (outs * 100 > thr_high * ins);
            light = (outs * 100 < thr_low * ins);
          end
          if (heavy) begin
            class_overload[c] = 1'b1;
            if (class_level[c] < level_cap) begin
              class_level[c] = class_level[c] + 1'b1;
              class_capacity[c] = granted_at(class_level[c]);
            end
          end else if (light) begin
            class_overload[c] = 1'b0;
            if (class_level[c] != 0) begin
              class_level[c] = class_level[c] - 1'b1;
              class_capacity[c] = granted_at(class_level[c]);
            end
          end
          in_tally[c] = '0;
          out_tally[c] = '0;
          g.class_index = c[CLASS_ID_W-1:0];
          g.capacity = class_capacity[c];
          g.level = class_level[c];
          g.overloaded = class_overload[c];
          g.last = (c == NCLS - 1);
          if (cur_beat.typed) begin
            g.capacity = cur_beat.cap;
            g.level = cur_beat.lvl;
            g.overloaded = cur_beat.ovl;
          end
          pending_grants.push_back(g);
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches = mismatches + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HIGH_LOAD:    thr_high = cfg_data[PCT_W-1:0];
          REG_LOW_LOAD:     thr_low = cfg_data[PCT_W-1:0];
          REG_STEP:         step_now = cfg_data[PCT_W-1:0];
          REG_MIN_CAPACITY: floor_now = cfg_data[PCT_W-1:0];
          REG_MAX_LEVEL:    level_cap = cfg_data[LEVEL_W-1:0];
          REG_INTERVAL:     interval_now = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_beat(in_action, in_class_id, in_amount);
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          $error("result for class %0d arrived with nothing expected", out_class_index);
          mismatches = mismatches + 1;
        end else begin
          head = pending_grants.pop_front();
          check_field("class_index", 32'(head.class_index), 32'(out_class_index));
          check_field("capacity", 32'(head.capacity), 32'(out_capacity));
          check_field("level", 32'(head.level), 32'(out_level));
          check_field("overloaded", 32'(head.overloaded), 32'(out_overloaded));
          check_field("last", 32'(head.last), 32'(out_last));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (flow_left == 0) begin
        flow = flow_t'($urandom_range(0, 2));
        flow_left = $urandom_range(8, 80);
      end
      flow_left = flow_left - 1;
      case (flow)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:    out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_beat(input load_beat_t b);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    cur_beat = b;
    in_valid <= 1'b1;
    in_action <= b.act;
    in_class_id <= b.cls;
    in_amount <= b.amt;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic load_beat_t random_beat();
    load_beat_t b;
    int pick;
    b = '0;
    pick = $urandom_range(0, 99);
    if (pick < 44)
      b.act = ACT_IN;
    else if (pick < 84)
      b.act = ACT_OUT;
    else if (pick < 97)
      b.act = ACT_TICK;
    else
      b.act = ACT_NONE;
    if ($urandom_range(0, 9) == 0)
      b.cls = CLASS_ID_W'($urandom_range(0, 15));
    else
      b.cls = CLASS_ID_W'($urandom_range(0, NCLS - 1));
    pick = $urandom_range(0, 9);
    if (pick < 7)
      b.amt = AMOUNT_W'($urandom_range(0, 300));
    else if (pick < 9)
      b.amt = AMOUNT_W'($urandom_range(0, 65535));
    else if ($urandom_range(0, 1) == 0)
      b.amt = '0;
    else
      b.amt = {AMOUNT_W{1'b1}};
    return b;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input int high, input int low, input int step, input int floor_pct,
                               input int max_lvl, input int interval);
    write_reg(REG_HIGH_LOAD, CFG_DATA_W'(high));
    write_reg(REG_LOW_LOAD, CFG_DATA_W'(low));
    write_reg(REG_STEP, CFG_DATA_W'(step));
    write_reg(REG_MIN_CAPACITY, CFG_DATA_W'(floor_pct));
    write_reg(REG_MAX_LEVEL, CFG_DATA_W'(max_lvl));
    write_reg(REG_INTERVAL, CFG_DATA_W'(interval));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_reg(REG_INTERVAL, 20'd1);
    foreach (probe_rows[k])
      push_beat(probe_rows[k]);
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0: apply_setting(80, 30, 10, 50, 7, 2);
        1: apply_setting(0, 100, 100, 0, 15, 1);
        2: apply_setting(100, 0, 0, 100, 0, 3);
        3: apply_setting(50, 50, 7, 120, 3, 1);
        6: apply_setting(90, 10, 33, 0, 15, 1048575);
        7: apply_setting(60, 40, 25, 20, 15, 0);
        default: apply_setting($urandom_range(0, 100), $urandom_range(0, 100),
                               $urandom_range(0, 100), $urandom_range(0, 100),
                               $urandom_range(0, 15), $urandom_range(1, 4));
      endcase
      if (phase == 1)
        hold_req = 1'b1;
      repeat ((phase == 6) ? 20 : 60)
        push_beat(random_beat());
    end
    wait_idle();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/clbc_pkg.sv
hw/rtl/clbc_ctrl.sv
hw/rtl/clbc_datapath.sv
hw/rtl/class_load_backpressure_controller.sv
hw/rtl/clbc_checker.sv
tb/tb.sv
